FILE: design/alfir_pkg.sv
// ----------------------------------------------------------------------------
// alfir_pkg
// Shared types and constants for the array list find/insert/remove unit.
// ----------------------------------------------------------------------------
package alfir_pkg;

  localparam int CAPACITY_DEF = 16;

  typedef enum logic [1:0] {
    OP_FIND   = 2'd0,
    OP_REMOVE = 2'd1,
    OP_INSERT = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHDN,
    S_SHUP,
    S_RDW,
    S_FIN
  } state_t;

endpackage

FILE: design/alfir_in_if.sv
// ----------------------------------------------------------------------------
// alfir_in_if
// Request channel: operation code, value and position with valid/ready.
// ----------------------------------------------------------------------------
interface alfir_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [31:0] value;
  logic [4:0]         position;

  modport source (output valid, output mode, output value, output position, input ready);
  modport sink   (input valid, input mode, input value, input position, output ready);
endinterface

FILE: design/alfir_out_if.sv
// ----------------------------------------------------------------------------
// alfir_out_if
// Result channel: status, match index, read data and entry count.
// ----------------------------------------------------------------------------
interface alfir_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [3:0]         found_index;
  logic signed [31:0] read_data;
  logic [4:0]         entry_count;

  modport source (output valid, output status, output found_index, output read_data,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input found_index, input read_data,
                  input entry_count, output ready);
endinterface

FILE: design/array_list_find_insert_remove_unit.sv
// ----------------------------------------------------------------------------
// array_list_find_insert_remove_unit
// Packed list of signed 32-bit entries in a single-port-write memory with a
// registered read; find, remove, insert and read run under a small sequencer.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                      | handshake
//  in_ch    | in  | mode, value, position                        | valid/ready
//  out_ch   | out | status, found_index, read_data, entry_count  | valid/ready
//
//  one request at a time; in_ch.ready is high only while the sequencer idles
//  find and remove scan from entry 0 up to the first match; remove then
//  shifts the later entries down by one; insert shifts the entries at or above
//  position up by one, top first, then writes the value; a full or out of
//  range request goes straight to the result
//  the memory's single registered read port paces the scan and both shifts
//  reset clears count and control state only; a result waiting on out_ch does
//  not stop the next request, only the final load of the output register waits
// ----------------------------------------------------------------------------
module array_list_find_insert_remove_unit
  import alfir_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  alfir_in_if.sink     in_ch,
  alfir_out_if.source  out_ch
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > 5) ? CW : 5;

  logic [31:0] mem [CAPACITY];
  logic [31:0] rdata_r;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;

  state_t        state_r, state_nxt;
  op_t           op_r, op_nxt;
  logic [31:0]   value_r, value_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic          cmp_vld_r, cmp_vld_nxt;
  logic [AW-1:0] cmp_idx_r, cmp_idx_nxt;
  logic          wv_r, wv_nxt;
  logic [AW-1:0] wa_r, wa_nxt;
  logic [AW-1:0] hit_r, hit_nxt;
  status_t       status_r, status_nxt;
  logic [31:0]   data_r, data_nxt;

  logic          out_valid_r, out_valid_nxt;
  status_t       out_status_r, out_status_nxt;
  logic [3:0]    out_idx_r, out_idx_nxt;
  logic [31:0]   out_data_r, out_data_nxt;
  logic [4:0]    out_cnt_r, out_cnt_nxt;

  logic [XW-1:0] pos_x, cnt_x, hit_x;
  logic          in_xfer;

  assign pos_x   = XW'(in_ch.position);
  assign cnt_x   = XW'(count_r);
  assign hit_x   = XW'(hit_r);
  assign in_xfer = in_ch.valid && in_ch.ready;

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.found_index = out_idx_r;
  assign out_ch.read_data   = out_data_r;
  assign out_ch.entry_count = out_cnt_r;

  // list storage, read every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    value_nxt      = value_r;
    pos_nxt        = pos_r;
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    rem_nxt        = rem_r;
    cmp_vld_nxt    = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    wv_nxt         = 1'b0;
    wa_nxt         = wa_r;
    hit_nxt        = hit_r;
    status_nxt     = status_r;
    data_nxt       = data_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;
    out_data_nxt   = out_data_r;
    out_cnt_nxt    = out_cnt_r;
    raddr          = pos_x[AW-1:0];
    we             = 1'b0;
    waddr          = wa_r;
    wdata          = rdata_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          op_nxt     = op_t'(in_ch.mode);
          value_nxt  = in_ch.value;
          pos_nxt    = pos_x[AW-1:0];
          status_nxt = ST_OK;
          hit_nxt    = '0;
          data_nxt   = '0;
          ptr_nxt    = '0;
          unique case (op_t'(in_ch.mode)) inside
            OP_FIND, OP_REMOVE: begin
              state_nxt = S_SCAN;
            end
            OP_INSERT: begin
              if (count_r >= CW'(CAPACITY)) begin
                status_nxt = ST_FULL;
                state_nxt  = S_FIN;
              end else if (pos_x > cnt_x) begin
                status_nxt = ST_RANGE;
                state_nxt  = S_FIN;
              end else begin
                ptr_nxt   = count_r - CW'(1);
                rem_nxt   = CW'(cnt_x - pos_x);
                state_nxt = S_SHUP;
              end
            end
            OP_READ: begin
              if (pos_x >= cnt_x) begin
                status_nxt = ST_RANGE;
                state_nxt  = S_FIN;
              end else begin
                state_nxt = S_RDW;
              end
            end
          endcase
        end
      end

      // reads issue one per cycle, each compare falls in the cycle after its read
      S_SCAN: begin
        raddr = ptr_r[AW-1:0];
        if (cmp_vld_r && rdata_r == value_r) begin
          hit_nxt = cmp_idx_r;
          if (op_r == OP_REMOVE) begin
            ptr_nxt   = CW'(cmp_idx_r) + CW'(1);
            state_nxt = S_SHDN;
          end else begin
            state_nxt = S_FIN;
          end
        end else if (ptr_r < count_r) begin
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = ptr_r[AW-1:0];
          ptr_nxt     = ptr_r + CW'(1);
        end else if (!cmp_vld_r) begin
          status_nxt = ST_NOT_FOUND;
          state_nxt  = S_FIN;
        end
      end

      // read entry i+1, write it to i on the next cycle
      S_SHDN: begin
        raddr = ptr_r[AW-1:0];
        if (wv_r) begin
          we = 1'b1;
        end
        if (ptr_r < count_r) begin
          wv_nxt  = 1'b1;
          wa_nxt  = ptr_r[AW-1:0] - AW'(1);
          ptr_nxt = ptr_r + CW'(1);
        end else if (!wv_r) begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_FIN;
        end
      end

      // walk down from the top, then drop the new value into place
      S_SHUP: begin
        raddr = ptr_r[AW-1:0];
        if (wv_r) begin
          we = 1'b1;
        end
        if (rem_r != '0) begin
          wv_nxt  = 1'b1;
          wa_nxt  = ptr_r[AW-1:0] + AW'(1);
          ptr_nxt = ptr_r - CW'(1);
          rem_nxt = rem_r - CW'(1);
        end else if (!wv_r) begin
          we        = 1'b1;
          waddr     = pos_r;
          wdata     = value_r;
          count_nxt = count_r + CW'(1);
          state_nxt = S_FIN;
        end
      end

      S_RDW: begin
        data_nxt  = rdata_r;
        state_nxt = S_FIN;
      end

      S_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_idx_nxt    = hit_x[3:0];
          out_data_nxt   = data_r;
          out_cnt_nxt    = cnt_x[4:0];
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cmp_vld_r   <= 1'b0;
      wv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      wv_r        <= wv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    value_r      <= value_nxt;
    pos_r        <= pos_nxt;
    ptr_r        <= ptr_nxt;
    rem_r        <= rem_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    wa_r         <= wa_nxt;
    hit_r        <= hit_nxt;
    status_r     <= status_nxt;
    data_r       <= data_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_data_r   <= out_data_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_FIN || state_r == S_RDW) |-> !we)
    else $error("memory write outside a shift");

  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r != S_IDLE)
    else $error("request transfer did not start the sequencer");

  a_count_change: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && count_r != $past(count_r)) |->
      ($past(state_r) == S_SHDN || $past(state_r) == S_SHUP))
    else $error("entry count changed outside a shift");

  a_fin_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && state_nxt == S_IDLE) |=> out_valid_r)
    else $error("finished request left no result");
`endif

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Sends directed and random find, remove, insert and read requests to the
// array list unit under bursty input and a stalling result side. Each result
// is compared against a behavioral list kept in step with every accepted
// request.
// ----------------------------------------------------------------------------
module testbench;
  import alfir_pkg::*;

  localparam int DEPTH        = CAPACITY_DEF;
  localparam int RANDOM_OPS   = 750;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    op_t         mode;
    logic [31:0] value;
    logic [4:0]  position;
  } list_req_t;

  typedef struct packed {
    status_t     status;
    logic [3:0]  found_index;
    logic [31:0] read_data;
    logic [4:0]  entry_count;
  } list_rsp_t;

  logic clk;
  logic rst_n;

  alfir_in_if  in_ch ();
  alfir_out_if out_ch ();

  array_list_find_insert_remove_unit #(
    .CAPACITY(DEPTH)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // behavioral list, advanced at each accepted request
  logic [31:0] list_entries [DEPTH];
  int          list_count;

  list_rsp_t   results_due [$];
  list_req_t   req_backlog [$];
  // contents as the generator expects them, used to aim finds and removes
  logic [31:0] plan_list [$];

  int        errors;
  int        reqs_sent;
  int        reqs_total;
  int        idle_cycles;
  int        peak_fill;
  int        op_hits [4];
  int        status_hits [4];
  bit        req_taken;
  int        burst_left;
  int        gap_left;
  int        pace_style;
  int        pace_timer;
  logic [15:0] ready_pat;
  list_req_t next_req;
  list_req_t seen_req;
  list_rsp_t due_rsp;

  function automatic list_rsp_t apply_list_op(list_req_t r);
    list_rsp_t rsp;
    int        hit;
    rsp.status      = ST_OK;
    rsp.found_index = '0;
    rsp.read_data   = '0;
    hit = -1;
    for (int i = 0; i < list_count; i++) begin
      if (hit < 0 && list_entries[i] == r.value) hit = i;
    end
    case (r.mode)
      OP_FIND, OP_REMOVE: begin
        if (hit < 0) begin
          rsp.status = ST_NOT_FOUND;
        end else begin
          rsp.found_index = 4'(hit);
          if (r.mode == OP_REMOVE) begin
            for (int i = hit; i + 1 < list_count; i++) list_entries[i] = list_entries[i + 1];
            list_count--;
          end
        end
      end
      OP_INSERT: begin
        if (list_count >= DEPTH) begin
          rsp.status = ST_FULL;
        end else if (int'(r.position) > list_count) begin
          rsp.status = ST_RANGE;
        end else begin
          for (int i = list_count; i > int'(r.position); i--) list_entries[i] = list_entries[i - 1];
          list_entries[r.position] = r.value;
          list_count++;
        end
      end
      default: begin
        if (int'(r.position) >= list_count) rsp.status = ST_RANGE;
        else rsp.read_data = list_entries[r.position];
      end
    endcase
    rsp.entry_count = 5'(list_count);
    return rsp;
  endfunction

  function automatic void queue_list_op(op_t m, logic [31:0] v, logic [4:0] p);
    list_req_t r;
    r.mode     = m;
    r.value    = v;
    r.position = p;
    req_backlog.push_back(r);
    if (m == OP_REMOVE) begin
      for (int i = 0; i < plan_list.size(); i++) begin
        if (plan_list[i] == v) begin
          plan_list.delete(i);
          break;
        end
      end
    end else if (m == OP_INSERT && plan_list.size() < DEPTH && int'(p) <= plan_list.size()) begin
      plan_list.insert(int'(p), v);
    end
  endfunction

  function automatic logic [31:0] pick_value(bit aim_at_list);
    int roll;
    roll = $urandom_range(0, 99);
    if (plan_list.size() > 0 && (aim_at_list ? roll < 65 : roll < 20))
      return plan_list[$urandom_range(0, plan_list.size() - 1)];
    roll = $urandom_range(0, 99);
    if (roll < 45) return 32'($urandom_range(0, 7));
    if (roll < 60) return (roll < 53) ? 32'h8000_0000 : 32'h7fff_ffff;
    return $urandom;
  endfunction

  task automatic check_field(string what, logic [31:0] exp_val, logic [31:0] act_val);
    if (act_val !== exp_val) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what,
               $signed(exp_val), $signed(act_val));
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // request driver: bursts of transfers separated by random gaps
  always @(negedge clk) begin
    if (rst_n && (!in_ch.valid || req_taken)) begin
      req_taken = 1'b0;
      if (gap_left > 0 || req_backlog.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_ch.valid <= 1'b0;
      end else begin
        next_req = req_backlog.pop_front();
        in_ch.mode     <= next_req.mode;
        in_ch.value    <= next_req.value;
        in_ch.position <= next_req.position;
        in_ch.valid    <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
      end
    end
  end

  // result side: always ready, a rotating stall pattern, or random stalls
  always @(negedge clk) begin
    if (pace_timer == 0) begin
      pace_style = $urandom_range(0, 2);
      pace_timer = $urandom_range(30, 150);
      ready_pat  = 16'($urandom) | 16'h0001;
    end else begin
      pace_timer--;
    end
    ready_pat = {ready_pat[14:0], ready_pat[15]};
    case (pace_style)
      0:       out_ch.ready <= 1'b1;
      1:       out_ch.ready <= ready_pat[0];
      default: out_ch.ready <= ($urandom_range(0, 2) != 0);
    endcase
  end

  // monitor, list tracking and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      idle_cycles++;
      if (out_ch.valid && out_ch.ready) begin
        idle_cycles = 0;
        if (results_due.size() == 0) begin
          errors++;
          $display("%0t: result with nothing outstanding, status %0d count %0d", $time,
                   out_ch.status, out_ch.entry_count);
        end else begin
          due_rsp = results_due.pop_front();
          check_field("status", 32'(due_rsp.status), 32'(out_ch.status));
          check_field("found_index", 32'(due_rsp.found_index), 32'(out_ch.found_index));
          check_field("read_data", due_rsp.read_data, out_ch.read_data);
          check_field("entry_count", 32'(due_rsp.entry_count), 32'(out_ch.entry_count));
          status_hits[due_rsp.status]++;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        idle_cycles = 0;
        seen_req.mode     = op_t'(in_ch.mode);
        seen_req.value    = in_ch.value;
        seen_req.position = in_ch.position;
        results_due.push_back(apply_list_op(seen_req));
        op_hits[seen_req.mode]++;
        if (list_count > peak_fill) peak_fill = list_count;
        reqs_sent++;
        req_taken = 1'b1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
                 idle_cycles, results_due.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    bit growing;
    int sz;
    int roll;
    op_t m;
    logic [4:0] p;

    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.mode      = OP_FIND;
    in_ch.value     = '0;
    in_ch.position  = '0;
    out_ch.ready    = 1'b0;
    list_count      = 0;
    errors          = 0;
    reqs_sent       = 0;
    idle_cycles     = 0;
    peak_fill       = 0;
    req_taken       = 1'b0;
    burst_left      = 1;
    gap_left        = 0;
    pace_style      = 0;
    pace_timer      = 0;
    ready_pat       = 16'h0001;
    foreach (op_hits[i]) op_hits[i] = 0;
    foreach (status_hits[i]) status_hits[i] = 0;
    foreach (list_entries[i]) list_entries[i] = '0;

    // empty list, then extremes, middle insert, duplicates, and end cases
    queue_list_op(OP_READ,   32'd0,          5'd0);
    queue_list_op(OP_FIND,   32'd0,          5'd0);
    queue_list_op(OP_REMOVE, 32'd0,          5'd0);
    queue_list_op(OP_INSERT, 32'd5,          5'd1);
    queue_list_op(OP_INSERT, 32'h8000_0000,  5'd0);
    queue_list_op(OP_INSERT, 32'h7fff_ffff,  5'd1);
    queue_list_op(OP_INSERT, 32'd0,          5'd0);
    queue_list_op(OP_INSERT, 32'hffff_ffff,  5'd1);
    queue_list_op(OP_INSERT, 32'hffff_ffff,  5'd4);
    queue_list_op(OP_FIND,   32'hffff_ffff,  5'd31);
    queue_list_op(OP_FIND,   32'h7fff_ffff,  5'd0);
    queue_list_op(OP_FIND,   32'd12345,      5'd0);
    queue_list_op(OP_READ,   32'd0,          5'd4);
    queue_list_op(OP_READ,   32'd0,          5'd5);
    queue_list_op(OP_READ,   32'hffff_ffff,  5'd31);
    queue_list_op(OP_INSERT, 32'd9,          5'd31);
    queue_list_op(OP_REMOVE, 32'hffff_ffff,  5'd0);
    queue_list_op(OP_REMOVE, 32'hffff_ffff,  5'd0);
    queue_list_op(OP_REMOVE, 32'd0,          5'd0);
    queue_list_op(OP_READ,   32'd0,          5'd0);
    queue_list_op(OP_INSERT, 32'h5555_5555,  5'd2);
    queue_list_op(OP_INSERT, 32'haaaa_aaaa,  5'd0);

    // alternate fill and drain phases so the full and empty ends are visited
    growing = 1'b1;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      sz = plan_list.size();
      if (growing && sz == DEPTH && $urandom_range(0, 7) == 0) growing = 1'b0;
      else if (!growing && sz == 0 && $urandom_range(0, 3) == 0) growing = 1'b1;
      roll = $urandom_range(0, 99);
      if (roll < 50) m = growing ? OP_INSERT : OP_REMOVE;
      else if (roll < 62) m = growing ? OP_REMOVE : OP_INSERT;
      else if (roll < 80) m = OP_FIND;
      else m = OP_READ;
      if (m == OP_INSERT)
        p = ($urandom_range(0, 99) < 85) ? 5'($urandom_range(0, sz)) : 5'($urandom_range(0, 31));
      else if (m == OP_READ && sz > 0 && $urandom_range(0, 99) < 85)
        p = 5'($urandom_range(0, sz - 1));
      else
        p = 5'($urandom_range(0, 31));
      queue_list_op(m, pick_value(m == OP_FIND || m == OP_REMOVE), p);
    end
    reqs_total = req_backlog.size();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (reqs_sent < reqs_total || results_due.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests: %0d find, %0d remove, %0d insert, %0d read; peak fill %0d",
             reqs_sent, op_hits[OP_FIND], op_hits[OP_REMOVE], op_hits[OP_INSERT],
             op_hits[OP_READ], peak_fill);
    $display("status mix: %0d ok, %0d not found, %0d full, %0d out of range; %0d errors",
             status_hits[ST_OK], status_hits[ST_NOT_FOUND], status_hits[ST_FULL],
             status_hits[ST_RANGE], errors);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
